[src/mseq_pkg.sv]
// Package for the macro event playback sequencer: default sizes, type and mode codes,
// channel item layouts and the controller state type.
// No dependencies.
package mseq_pkg;

  localparam int MAX_MACROS = 8;
  localparam int MAX_LENGTH = 32;
  localparam int CODE_BITS  = 16;

  localparam int TYPE_W = 3;

  localparam logic [TYPE_W-1:0] TYPE_KEY       = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_MOUSE     = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_AUTOMOUSE = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_WHEEL     = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_CONSUMER  = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_SYSTEM    = 3'd5;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_LENGTH  = 2'd1,
    MODE_TRIGGER = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    mode_t             mode;
    logic [2:0]        slot;
    logic [4:0]        position;
    logic [TYPE_W-1:0] event_type;
    logic [15:0]       event_code;
    logic [4:0]        length;
    logic              keyboard_idle;
    logic              nkro_idle;
    logic              mouse_idle;
    logic              extrakey_idle;
  } in_item_t;

  typedef struct packed {
    logic              send_valid;
    logic [TYPE_W-1:0] send_type;
    logic [15:0]       send_code;
    logic              send_pressed;
    logic              playing;
    logic              rejected;
  } out_item_t;

endpackage

[src/mseq_in_if.sv]
// Request channel of the playback sequencer: valid, ready and one request item.
// Depends on mseq_pkg.
interface mseq_in_if;
  logic               valid;
  logic               ready;
  mseq_pkg::in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[src/mseq_out_if.sv]
// Result channel of the playback sequencer: valid, ready and one result item.
// Depends on mseq_pkg.
interface mseq_out_if;
  logic                valid;
  logic                ready;
  mseq_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[src/mseq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/macro_event_playback_sequencer.sv]
// Macro event playback sequencer: event and length stores in RAM, playback controller.
// Depends on mseq_pkg, mseq_in_if, mseq_out_if and mseq_ram.
//
//   channel  role    item          transfer
//   req      sink    in_item_t     valid & ready: load, set length, trigger or tick
//   rsp      source  out_item_t    valid & ready: one result per request
//
// Each request is accepted in the idle state, which writes the stores or issues the
// event and length reads; the execute state then forms the result from the registered RAM data.
// No new request is taken until the current one has left the execute state.
// After reset a clearing pass walks all MAX_MACROS * MAX_LENGTH event addresses
// (256 by default) and zeroes both stores, while req.ready stays low.
// A result waiting in the output register stalls the controller only in its execute state.
module macro_event_playback_sequencer #(
  parameter int MAX_MACROS = mseq_pkg::MAX_MACROS,
  parameter int MAX_LENGTH = mseq_pkg::MAX_LENGTH,
  parameter int CODE_BITS  = mseq_pkg::CODE_BITS
) (
  input logic        clk,
  input logic        rst,
  mseq_in_if.sink    req,
  mseq_out_if.source rsp
);

  localparam int EV_DEPTH = MAX_MACROS * MAX_LENGTH;
  localparam int EV_AW    = EV_DEPTH > 1 ? $clog2(EV_DEPTH) : 1;
  localparam int EV_W     = mseq_pkg::TYPE_W + CODE_BITS;
  localparam int LEN_AW   = MAX_MACROS > 1 ? $clog2(MAX_MACROS) : 1;
  localparam int CLR_W    = $clog2(EV_DEPTH + 1);

  localparam logic [1:0] PH_PRESS   = 2'd0;
  localparam logic [1:0] PH_RELEASE = 2'd1;
  localparam logic [1:0] PH_ADVANCE = 2'd2;

  mseq_pkg::state_t    state, state_next;
  logic [CLR_W-1:0]    clr_cnt;
  logic                active, active_next;
  logic [2:0]          cur_slot;
  logic [4:0]          play_pos, play_pos_next;
  logic [1:0]          phase, phase_next;
  mseq_pkg::in_item_t  op_item;
  logic                op_reject;
  logic                out_valid;
  mseq_pkg::out_item_t out_data;
  mseq_pkg::out_item_t res;

  logic              acc;
  logic              slot_ok, pos_ok, len_bad;
  logic              out_free, exec_done, clearing;
  logic              ev_we, len_we, rd_en;
  logic [EV_AW-1:0]  ev_waddr, ev_raddr;
  logic [EV_W-1:0]   ev_wdata, ev_rd;
  logic [LEN_AW-1:0] len_waddr;
  logic [4:0]        len_wdata, len_rd;
  logic [mseq_pkg::TYPE_W-1:0] ev_type;
  logic [CODE_BITS-1:0]        ev_code;
  logic              chan_ok;

  assign acc       = req.valid & req.ready;
  assign slot_ok   = 32'(req.data.slot) < 32'(MAX_MACROS);
  assign pos_ok    = 32'(req.data.position) < 32'(MAX_LENGTH);
  assign len_bad   = 32'(req.data.length) > 32'(MAX_LENGTH - 2);
  assign out_free  = !out_valid || rsp.ready;
  assign clearing  = (state == mseq_pkg::ST_CLEAR);
  assign exec_done = (state == mseq_pkg::ST_EXEC) && out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mseq_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_W'(EV_DEPTH - 1)) state_next = mseq_pkg::ST_IDLE;
      end
      mseq_pkg::ST_IDLE: begin
        if (acc) state_next = mseq_pkg::ST_EXEC;
      end
      mseq_pkg::ST_EXEC: begin
        if (out_free) state_next = mseq_pkg::ST_IDLE;
      end
      default: state_next = mseq_pkg::ST_IDLE;
    endcase
  end

  // store accesses; the clearing pass owns the write ports
  always_comb begin
    req.ready = (state == mseq_pkg::ST_IDLE);
    ev_we     = clearing ||
                (acc && req.data.mode == mseq_pkg::MODE_LOAD && slot_ok && pos_ok);
    ev_waddr  = clearing ? EV_AW'(clr_cnt)
                         : EV_AW'(32'(req.data.slot) * 32'(MAX_LENGTH)
                                  + 32'(req.data.position));
    ev_wdata  = clearing ? '0 : {req.data.event_type, CODE_BITS'(req.data.event_code)};
    len_we    = (clearing && 32'(clr_cnt) < 32'(MAX_MACROS)) ||
                (acc && req.data.mode == mseq_pkg::MODE_LENGTH && slot_ok && !len_bad);
    len_waddr = clearing ? LEN_AW'(clr_cnt) : LEN_AW'(req.data.slot);
    len_wdata = clearing ? 5'd0 : req.data.length;
    rd_en     = acc && req.data.mode == mseq_pkg::MODE_TICK;
    ev_raddr  = EV_AW'(32'(cur_slot) * 32'(MAX_LENGTH) + 32'(play_pos));
  end

  mseq_ram #(.WIDTH(EV_W), .DEPTH(EV_DEPTH)) u_event_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .re    (rd_en),
    .raddr (ev_raddr),
    .rdata (ev_rd)
  );

  mseq_ram #(.WIDTH(5), .DEPTH(MAX_MACROS)) u_length_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (rd_en),
    .raddr (LEN_AW'(cur_slot)),
    .rdata (len_rd)
  );

  assign ev_type = ev_rd[CODE_BITS +: mseq_pkg::TYPE_W];
  assign ev_code = ev_rd[CODE_BITS-1:0];

  always_comb begin
    unique case (ev_type)
      mseq_pkg::TYPE_KEY:        chan_ok = op_item.keyboard_idle && op_item.nkro_idle;
      mseq_pkg::TYPE_MOUSE,
      mseq_pkg::TYPE_AUTOMOUSE,
      mseq_pkg::TYPE_WHEEL:      chan_ok = op_item.mouse_idle;
      mseq_pkg::TYPE_CONSUMER,
      mseq_pkg::TYPE_SYSTEM:     chan_ok = op_item.extrakey_idle;
      default:                   chan_ok = 1'b1;
    endcase
  end

  // tick step and result
  always_comb begin
    res           = '0;
    active_next   = active;
    play_pos_next = play_pos;
    phase_next    = phase;
    if (op_item.mode == mseq_pkg::MODE_TICK && active) begin
      if (32'(play_pos) >= 32'(MAX_LENGTH)) begin
        active_next = 1'b0;
      end else if (phase == PH_PRESS || phase == PH_RELEASE) begin
        if (chan_ok) begin
          // unknown types pass silently
          if (ev_type <= mseq_pkg::TYPE_SYSTEM) begin
            res.send_valid   = 1'b1;
            res.send_type    = ev_type;
            res.send_code    = 16'(ev_code);
            res.send_pressed = (phase == PH_PRESS) || (ev_type == mseq_pkg::TYPE_SYSTEM);
          end
          phase_next = phase + 2'd1;
        end
      end else begin
        phase_next    = PH_PRESS;
        play_pos_next = play_pos + 5'd1;
        if ({1'b0, play_pos} + 6'd1 >= {1'b0, len_rd}) active_next = 1'b0;
      end
    end
    res.rejected = op_reject;
    res.playing  = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mseq_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      active    <= 1'b0;
      cur_slot  <= '0;
      play_pos  <= '0;
      phase     <= PH_PRESS;
      op_reject <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + CLR_W'(1);
      if (acc) begin
        op_reject <= req.data.mode == mseq_pkg::MODE_LENGTH && slot_ok && len_bad;
        if (req.data.mode == mseq_pkg::MODE_TRIGGER && slot_ok) begin
          cur_slot <= req.data.slot;
          play_pos <= '0;
          phase    <= PH_PRESS;
          active   <= 1'b1;
        end
      end
      if (exec_done) begin
        active    <= active_next;
        play_pos  <= play_pos_next;
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) op_item <= req.data;
    if (exec_done) out_data <= res;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == mseq_pkg::ST_EXEC))
    else $error("accepted request did not enter execute");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (32'(play_pos) < 32'(MAX_LENGTH)))
    else $error("play position beyond slot storage while playing");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PRESS || phase == PH_RELEASE || phase == PH_ADVANCE))
    else $error("illegal playback phase");

  a_reject_mode: assert property (@(posedge clk) disable iff (rst)
    ((state == mseq_pkg::ST_EXEC) && op_reject) |-> (op_item.mode == mseq_pkg::MODE_LENGTH))
    else $error("reject flagged on a request other than set length");

  a_emit_active: assert property (@(posedge clk) disable iff (rst)
    (exec_done && res.send_valid) |-> (active && op_item.mode == mseq_pkg::MODE_TICK))
    else $error("event emitted outside an active tick");
`endif

endmodule

[verif/macro_event_playback_sequencer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for macro_event_playback_sequencer: a predictor of the slot stores
// and the press/release/advance playback, random idling on both channels.
// Depends on mseq_pkg, mseq_in_if, mseq_out_if and the sequencer RTL.
module macro_event_playback_sequencer_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IN_SIDE = 0;
  localparam int OUT_SIDE = 1;
  localparam int TW = mseq_pkg::TYPE_W;

  typedef enum logic [1:0] {
    PH_PRESS,
    PH_RELEASE,
    PH_ADVANCE
  } play_phase_t;

  logic clk;
  logic rst;

  mseq_in_if  req_ch();
  mseq_out_if rsp_ch();

  macro_event_playback_sequencer DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predictor state: event and length stores plus the playback position.
  logic [TW+15:0]     ev_mem [mseq_pkg::MAX_MACROS][mseq_pkg::MAX_LENGTH];
  logic [4:0]         len_mem [mseq_pkg::MAX_MACROS];
  logic               play_on;
  logic [2:0]         play_slot;
  int                 play_pos;
  play_phase_t        play_phase;

  mseq_pkg::in_item_t  pending_q[$];
  mseq_pkg::out_item_t result_q[$];
  int        mismatch_count;
  int        calm_left[2];
  int        send_gap;
  int        stall_left;
  int        idle_cycles;

  function automatic int draw_gap(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic channel_free(input logic [TW-1:0] et,
                                        input mseq_pkg::in_item_t it);
    case (et)
      mseq_pkg::TYPE_KEY: return it.keyboard_idle & it.nkro_idle;
      mseq_pkg::TYPE_MOUSE, mseq_pkg::TYPE_AUTOMOUSE, mseq_pkg::TYPE_WHEEL:
        return it.mouse_idle;
      mseq_pkg::TYPE_CONSUMER, mseq_pkg::TYPE_SYSTEM: return it.extrakey_idle;
      default: return 1'b1;
    endcase
  endfunction

  task automatic predict_playback(input mseq_pkg::in_item_t it);
    mseq_pkg::out_item_t r;
    logic [TW+15:0]      ev;
    logic [TW-1:0]       et;
    r = '0;
    case (it.mode)
      mseq_pkg::MODE_LOAD: ev_mem[it.slot][it.position] = {it.event_type, it.event_code};
      mseq_pkg::MODE_LENGTH: begin
        if (int'(it.length) > mseq_pkg::MAX_LENGTH - 2) r.rejected = 1'b1;
        else len_mem[it.slot] = it.length;
      end
      mseq_pkg::MODE_TRIGGER: begin
        play_slot = it.slot;
        play_pos = 0;
        play_phase = PH_PRESS;
        play_on = 1'b1;
      end
      default: begin
        if (play_on) begin
          ev = ev_mem[play_slot][play_pos];
          et = ev[TW+15:16];
          if (play_phase == PH_ADVANCE) begin
            play_phase = PH_PRESS;
            play_pos++;
            if (play_pos >= int'(len_mem[play_slot])) play_on = 1'b0;
          end else if (channel_free(et, it)) begin
            // unknown types step through both phases without a transfer
            if (et <= mseq_pkg::TYPE_SYSTEM) begin
              r.send_valid = 1'b1;
              r.send_type = et;
              r.send_code = ev[15:0];
              r.send_pressed = (play_phase == PH_PRESS) || (et == mseq_pkg::TYPE_SYSTEM);
            end
            play_phase = (play_phase == PH_PRESS) ? PH_RELEASE : PH_ADVANCE;
          end
        end
      end
    endcase
    r.playing = play_on;
    result_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic mseq_pkg::in_item_t mk(input mseq_pkg::mode_t m, input int s,
                                            input int p, input int et, input int code,
                                            input int len, input logic [3:0] idle);
    mseq_pkg::in_item_t it;
    it.mode = m;
    it.slot = s[2:0];
    it.position = p[4:0];
    it.event_type = et[TW-1:0];
    it.event_code = code[15:0];
    it.length = len[4:0];
    {it.keyboard_idle, it.nkro_idle, it.mouse_idle, it.extrakey_idle} = idle;
    return it;
  endfunction

  function automatic logic [3:0] rand_idle();
    return {$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
            $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0};
  endfunction

  function automatic mseq_pkg::in_item_t noise_item();
    return mk(mseq_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, 7),
              $urandom_range(0, 31), $urandom_range(0, 7), $urandom,
              $urandom_range(0, 31), rand_idle());
  endfunction

  // Load a slot, size it, trigger it and tick it through, with the odd write or
  // retrigger landing mid-playback.
  task automatic add_playback_run();
    int s;
    int n;
    int len;
    int ticks;
    int r;
    s = $urandom_range(0, 7);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
    for (int p = 0; p < n; p++) begin
      pending_q.push_back(mk(mseq_pkg::MODE_LOAD, s, p, $urandom_range(0, 7), $urandom,
                             $urandom_range(0, 31), rand_idle()));
    end
    r = $urandom_range(0, 9);
    if (r == 0) len = 31;
    else if (r == 1) len = 0;
    else if (r == 2) len = $urandom_range(0, 30);
    else len = n;
    pending_q.push_back(mk(mseq_pkg::MODE_LENGTH, s, $urandom_range(0, 31),
                           $urandom_range(0, 7), $urandom, len, rand_idle()));
    pending_q.push_back(mk(mseq_pkg::MODE_TRIGGER, s, $urandom_range(0, 31),
                           $urandom_range(0, 7), $urandom, $urandom_range(0, 31),
                           rand_idle()));
    ticks = 3 * n + $urandom_range(0, 6);
    for (int t = 0; t < ticks; t++) begin
      r = $urandom_range(0, 59);
      if (r < 3) pending_q.push_back(mk(mseq_pkg::MODE_LOAD, s, $urandom_range(0, n),
                                        $urandom_range(0, 7), $urandom,
                                        $urandom_range(0, 31), rand_idle()));
      else if (r < 5) pending_q.push_back(mk(mseq_pkg::MODE_LENGTH, s,
                                             $urandom_range(0, 31), 0, $urandom,
                                             $urandom_range(0, 31), rand_idle()));
      else if (r == 5) pending_q.push_back(mk(mseq_pkg::MODE_TRIGGER, $urandom_range(0, 7),
                                              0, 0, $urandom, 0, rand_idle()));
      pending_q.push_back(mk(mseq_pkg::MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 31),
                             $urandom_range(0, 7), $urandom, $urandom_range(0, 31),
                             rand_idle()));
    end
  endtask

  // Request driver: hold each item until its transfer, then pause at random.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_q.size() > 0) begin
        req_ch.data <= pending_q.pop_front();
        req_ch.valid <= 1'b1;
        send_gap <= draw_gap(IN_SIDE);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) predict_playback(req_ch.data);
  end

  // Result side: random backpressure, then compare against the oldest prediction.
  always @(posedge clk) begin
    int g;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      g = draw_gap(OUT_SIDE);
      rsp_ch.ready <= (g == 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mseq_pkg::out_item_t want;
    mseq_pkg::out_item_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(got), 32'd0);
      end else begin
        want = result_q.pop_front();
        if (got.send_valid !== want.send_valid)
          report_mismatch("send_valid", 32'(got.send_valid), 32'(want.send_valid));
        if (got.send_type !== want.send_type)
          report_mismatch("send_type", 32'(got.send_type), 32'(want.send_type));
        if (got.send_code !== want.send_code)
          report_mismatch("send_code", 32'(got.send_code), 32'(want.send_code));
        if (got.send_pressed !== want.send_pressed)
          report_mismatch("send_pressed", 32'(got.send_pressed), 32'(want.send_pressed));
        if (got.playing !== want.playing)
          report_mismatch("playing", 32'(got.playing), 32'(want.playing));
        if (got.rejected !== want.rejected)
          report_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
      end
    end
  end

  // Watchdog: the clearing pass after reset counts as a quiet stretch too.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL macro_event_playback_sequencer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stop_at;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    mismatch_count = 0;
    calm_left[IN_SIDE] = 0;
    calm_left[OUT_SIDE] = 0;
    for (int s = 0; s < mseq_pkg::MAX_MACROS; s++) begin
      len_mem[s] = '0;
      for (int p = 0; p < mseq_pkg::MAX_LENGTH; p++) ev_mem[s][p] = '0;
    end
    play_on = 1'b0;
    play_slot = '0;
    play_pos = 0;
    play_phase = PH_PRESS;

    // directed: idle tick, field extremes, rejected length, zero-length slot,
    // key readiness, system release, unknown type, retrigger, write during playback
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_LOAD, 0, 0, int'(mseq_pkg::TYPE_KEY), 'hFFFF, 0,
                           4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_LOAD, 7, 31, 7, 'h0000, 31, 4'b0000));
    pending_q.push_back(mk(mseq_pkg::MODE_LOAD, 1, 0, int'(mseq_pkg::TYPE_SYSTEM), 'hA5A5, 0,
                           4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_LOAD, 1, 1, 6, 'h5A5A, 0, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_LOAD, 1, 2, int'(mseq_pkg::TYPE_WHEEL), 'h1234, 0,
                           4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_LENGTH, 7, 0, 0, 0, 31, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_LENGTH, 7, 0, 0, 0, mseq_pkg::MAX_LENGTH - 2,
                           4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_LENGTH, 1, 0, 0, 0, 3, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_TRIGGER, 0, 0, 0, 0, 0, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b0111));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b1011));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_TRIGGER, 1, 0, 0, 0, 0, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b1110));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b0001));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b0001));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b0000));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b0000));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b0000));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b0000));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b1101));
    pending_q.push_back(mk(mseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 4'b0010));
    pending_q.push_back(mk(mseq_pkg::MODE_TRIGGER, 7, 0, 0, 0, 0, 4'b1111));
    pending_q.push_back(mk(mseq_pkg::MODE_LENGTH, 7, 0, 0, 0, 0, 4'b1111));

    stop_at = pending_q.size() + RANDOM_ITEMS;
    while (pending_q.size() < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        add_playback_run();
      end else begin
        repeat ($urandom_range(1, 5)) pending_q.push_back(noise_item());
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || req_ch.valid || result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS macro_event_playback_sequencer");
    end else begin
      $display("FAIL macro_event_playback_sequencer");
    end
    $finish;
  end

endmodule
